### hdl/two_class_priority_queue_macros.svh
// Assertion macros for the two-class priority queue.
// Each macro expects signals named clk and rst in the scope of its use.
`ifndef TWO_CLASS_PRIORITY_QUEUE_MACROS_SVH
`define TWO_CLASS_PRIORITY_QUEUE_MACROS_SVH

// Condition holds at every edge outside reset.
`define TCPQ_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define TCPQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define TCPQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/tcpq_pkg.sv
// ----------------------------------------------------------------------------
// tcpq_pkg
// Shared constants, codes, types and ring index helper for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

package tcpq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_WIDTH    = 32;

  localparam int SEQ_W   = 32;
  localparam int OUT_ID_W = 32;
  localparam int AHEAD_W = 6;
  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_W = SEQ_W + ID_WIDTH;

  // request op codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_LIST   = 2'd2;

  // entry classes
  localparam logic [1:0] CLS_ORD  = 2'd0;
  localparam logic [1:0] CLS_PRIO = 2'd1;

  // result kinds
  localparam logic [2:0] KIND_ACK      = 3'd0;
  localparam logic [2:0] KIND_REMOVED  = 3'd1;
  localparam logic [2:0] KIND_FAIL     = 3'd2;
  localparam logic [2:0] KIND_LIST_HDR = 3'd3;
  localparam logic [2:0] KIND_LIST_ENT = 3'd4;
  localparam logic [2:0] KIND_REJECT   = 3'd5;

  typedef struct packed {
    logic               push;
    logic               pop;
    logic               rd_en;
    logic [PTR_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0] wdata;
  } ring_cmd_t;

  typedef struct packed {
    logic [PTR_W-1:0] head;
    logic [CNT_W-1:0] count;
  } ring_stat_t;

  // Ring slot at base + off, wrapped at QUEUE_DEPTH; off never exceeds the depth.
  function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

`default_nettype wire

### hdl/tcpq_in_if.sv
// ----------------------------------------------------------------------------
// tcpq_in_if
// Request channel: op, customer id and class with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcpq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] customer_id;
  logic [1:0]  entry_class;

  modport source (output valid, output op, output customer_id, output entry_class,
                  input ready);
  modport sink   (input valid, input op, input customer_id, input entry_class,
                  output ready);
endinterface

`default_nettype wire

### hdl/tcpq_out_if.sv
// ----------------------------------------------------------------------------
// tcpq_out_if
// Result channel: one result item per transfer with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcpq_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] seq_number;
  logic [31:0] customer_id_res;
  logic        entry_class_res;
  logic [5:0]  ahead_count;
  logic        last;

  modport source (output valid, output kind, output seq_number, output customer_id_res,
                  output entry_class_res, output ahead_count, output last,
                  input ready);
  modport sink   (input valid, input kind, input seq_number, input customer_id_res,
                  input entry_class_res, input ahead_count, input last,
                  output ready);
endinterface

`default_nettype wire

### hdl/tcpq_ring.sv
// ----------------------------------------------------------------------------
// tcpq_ring
// One FIFO ring: entry memory with registered read, head pointer and count.
// ----------------------------------------------------------------------------
`default_nettype none

module tcpq_ring
  import tcpq_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ring_cmd_t          cmd,
  output ring_stat_t              stat,
  output logic [ENTRY_W-1:0]      rdata
);

  logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   head;
  logic [CNT_W-1:0]   count;
  logic [PTR_W-1:0]   tail;

  assign tail = ring_add(head, count);

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[tail] <= cmd.wdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[cmd.rd_addr];
    end
  end

  // push and pop never coincide: no request does both
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (cmd.push) begin
      count <= count + CNT_W'(1);
    end else if (cmd.pop) begin
      head  <= ring_add(head, CNT_W'(1));
      count <= count - CNT_W'(1);
    end
  end

  assign stat.head  = head;
  assign stat.count = count;

endmodule

`default_nettype wire

### hdl/tcpq_ctrl.sv
// ----------------------------------------------------------------------------
// tcpq_ctrl
// Request decode, arrival counter, list walk and result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcpq_ctrl
  import tcpq_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  tcpq_in_if.sink            req,
  tcpq_out_if.source         rsp,
  input  wire ring_stat_t    pstat,
  input  wire ring_stat_t    ostat,
  input  wire [ENTRY_W-1:0]  prdata,
  input  wire [ENTRY_W-1:0]  ordata,
  output ring_cmd_t          pcmd,
  output ring_cmd_t          ocmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_OUT  = 4'b0010,
    S_LRD  = 4'b0100,
    S_LOUT = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [SEQ_W-1:0]    arrival;
  logic [SEQ_W-1:0]    arrival_next;

  // pending result of the current request
  logic [2:0]          res_kind;
  logic [SEQ_W-1:0]    res_seq;
  logic [OUT_ID_W-1:0] res_id;
  logic                res_cls;
  logic [AHEAD_W-1:0]  res_ahead;
  logic                res_last;
  logic                res_mem;

  // list walk
  logic                list_cls;
  logic [PTR_W-1:0]    list_ptr;
  logic [CNT_W-1:0]    list_left;

  // output register
  logic                ov;
  logic [2:0]          o_kind;
  logic [SEQ_W-1:0]    o_seq;
  logic [OUT_ID_W-1:0] o_id;
  logic                o_cls;
  logic [AHEAD_W-1:0]  o_ahead;
  logic                o_last;

  logic                accept;
  logic                out_free;
  logic                p_full, o_full, p_empty, o_empty;
  logic [ID_WIDTH-1:0] in_id;
  logic [ENTRY_W-1:0]  sel_rdata;
  logic [ENTRY_W-1:0]  list_rdata;
  logic                list_final;

  assign accept       = req.valid && req.ready;
  assign req.ready    = (state == S_IDLE);
  assign out_free     = !ov || rsp.ready;
  assign arrival_next = arrival + SEQ_W'(1);
  assign in_id        = req.customer_id[ID_WIDTH-1:0];
  assign p_full       = (pstat.count == CNT_W'(QUEUE_DEPTH));
  assign o_full       = (ostat.count == CNT_W'(QUEUE_DEPTH));
  assign p_empty      = (pstat.count == '0);
  assign o_empty      = (ostat.count == '0);
  assign sel_rdata    = res_cls ? prdata : ordata;
  assign list_rdata   = list_cls ? prdata : ordata;
  assign list_final   = (list_left == CNT_W'(1)) && (!list_cls || o_empty);

  // ring commands
  always_comb begin
    pcmd         = '0;
    ocmd         = '0;
    pcmd.wdata   = {arrival_next, in_id};
    ocmd.wdata   = {arrival_next, in_id};
    pcmd.rd_addr = (state == S_LRD) ? list_ptr : pstat.head;
    ocmd.rd_addr = (state == S_LRD) ? list_ptr : ostat.head;
    if (accept && req.op == OP_INSERT) begin
      pcmd.push = (req.entry_class == CLS_PRIO) && !p_full;
      ocmd.push = (req.entry_class == CLS_ORD) && !o_full;
    end
    if (accept && req.op == OP_REMOVE) begin
      pcmd.pop   = !p_empty;
      pcmd.rd_en = !p_empty;
      ocmd.pop   = p_empty && !o_empty;
      ocmd.rd_en = p_empty && !o_empty;
    end
    if (state == S_LRD) begin
      pcmd.rd_en = list_cls;
      ocmd.rd_en = !list_cls;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (req.op == OP_REMOVE || req.op == OP_LIST) begin
            state_next = S_OUT;
          end else if (req.op == OP_INSERT &&
                       (req.entry_class == CLS_ORD || req.entry_class == CLS_PRIO)) begin
            state_next = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_next = (res_kind == KIND_LIST_HDR && !res_last) ? S_LRD : S_IDLE;
        end
      end
      S_LRD: state_next = S_LOUT;
      S_LOUT: begin
        if (out_free) begin
          state_next = list_final ? S_IDLE : S_LRD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      arrival <= '0;
    end else begin
      state <= state_next;
      if (accept && req.op == OP_INSERT) begin
        arrival <= arrival_next;
      end
    end
  end

  // capture the pending result and list walk state
  always_ff @(posedge clk) begin
    if (accept) begin
      case (req.op)
        OP_INSERT: begin
          res_seq  <= arrival_next;
          res_id   <= OUT_ID_W'(in_id);
          res_last <= 1'b1;
          res_mem  <= 1'b0;
          if (req.entry_class == CLS_PRIO) begin
            res_cls   <= 1'b1;
            res_kind  <= p_full ? KIND_REJECT : KIND_ACK;
            res_ahead <= p_full ? '0 : AHEAD_W'(pstat.count);
          end else begin
            res_cls   <= 1'b0;
            res_kind  <= o_full ? KIND_REJECT : KIND_ACK;
            res_ahead <= o_full ? '0 : AHEAD_W'(pstat.count) + AHEAD_W'(ostat.count);
          end
        end
        OP_REMOVE: begin
          res_seq   <= '0;
          res_id    <= '0;
          res_ahead <= '0;
          res_last  <= 1'b1;
          // class follows the ring taken; both empty leaves it clear
          res_cls   <= !p_empty;
          res_mem   <= !p_empty || !o_empty;
          res_kind  <= (!p_empty || !o_empty) ? KIND_REMOVED : KIND_FAIL;
        end
        OP_LIST: begin
          res_seq   <= '0;
          res_id    <= '0;
          res_cls   <= 1'b0;
          res_ahead <= '0;
          res_mem   <= 1'b0;
          res_kind  <= KIND_LIST_HDR;
          res_last  <= p_empty && o_empty;
          list_cls  <= !p_empty;
          list_ptr  <= !p_empty ? pstat.head : ostat.head;
          list_left <= !p_empty ? pstat.count : ostat.count;
        end
        default: res_kind <= KIND_FAIL;
      endcase
    end else if (state == S_LOUT && out_free) begin
      if (list_left == CNT_W'(1)) begin
        // switch to the ordinary ring once the priority ring is done
        list_cls  <= 1'b0;
        list_ptr  <= ostat.head;
        list_left <= ostat.count;
      end else begin
        list_ptr  <= ring_add(list_ptr, CNT_W'(1));
        list_left <= list_left - CNT_W'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      ov <= 1'b1;
    end else if (state == S_LOUT && out_free) begin
      ov <= 1'b1;
    end else if (rsp.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      o_kind  <= res_kind;
      o_seq   <= res_mem ? sel_rdata[ENTRY_W-1:ID_WIDTH] : res_seq;
      o_id    <= res_mem ? OUT_ID_W'(sel_rdata[ID_WIDTH-1:0]) : res_id;
      o_cls   <= res_cls;
      o_ahead <= res_ahead;
      o_last  <= res_last;
    end else if (state == S_LOUT && out_free) begin
      o_kind  <= KIND_LIST_ENT;
      o_seq   <= list_rdata[ENTRY_W-1:ID_WIDTH];
      o_id    <= OUT_ID_W'(list_rdata[ID_WIDTH-1:0]);
      o_cls   <= list_cls;
      o_ahead <= '0;
      o_last  <= list_final;
    end
  end

  assign rsp.valid           = ov;
  assign rsp.kind            = o_kind;
  assign rsp.seq_number      = o_seq;
  assign rsp.customer_id_res = o_id;
  assign rsp.entry_class_res = o_cls;
  assign rsp.ahead_count     = o_ahead;
  assign rsp.last            = o_last;

endmodule

`default_nettype wire

### hdl/two_class_priority_queue.sv
// ----------------------------------------------------------------------------
// two_class_priority_queue
// Strict-priority queue over a priority ring and an ordinary ring.
// ----------------------------------------------------------------------------
// req takes one request per valid/ready transfer: insert (customer id and
// class), remove, or list. rsp returns results in order; the final result of
// each request has last set. Insert stamps the next arrival number and acks
// with the count of entries that leave before it, or rejects at a full ring;
// an unknown class burns an arrival number and gives no result. Remove takes
// the priority head, else the ordinary head, else reports failure. List
// gives a header, then every priority entry, then every ordinary entry.
// Insert and remove: the result goes via S_OUT into the output register,
// and req is ready again once it is loaded. List: the header goes out via
// S_OUT, then each entry gets a registered ring read in S_LRD and is loaded
// into the output register in S_LOUT. Reset empties both rings and zeroes
// the arrival counter; ring memories are not cleared. A stall on rsp holds
// the output register and the sequencer; req is ready only between requests.
// ----------------------------------------------------------------------------
`default_nettype none

module two_class_priority_queue
  import tcpq_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  tcpq_in_if.sink     req,
  tcpq_out_if.source  rsp
);

  ring_cmd_t          pcmd, ocmd;
  ring_stat_t         pstat, ostat;
  logic [ENTRY_W-1:0] prdata, ordata;

  // priority ring
  tcpq_ring u_pring (
    .clk   (clk),
    .rst   (rst),
    .cmd   (pcmd),
    .stat  (pstat),
    .rdata (prdata)
  );

  // ordinary ring
  tcpq_ring u_oring (
    .clk   (clk),
    .rst   (rst),
    .cmd   (ocmd),
    .stat  (ostat),
    .rdata (ordata)
  );

  // decode, sequence and drive results
  tcpq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .rsp    (rsp),
    .pstat  (pstat),
    .ostat  (ostat),
    .prdata (prdata),
    .ordata (ordata),
    .pcmd   (pcmd),
    .ocmd   (ocmd)
  );

endmodule

`default_nettype wire

### hdl/tcpq_checker.sv
// ----------------------------------------------------------------------------
// tcpq_checker
// Port-level checks on the queue's result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "two_class_priority_queue_macros.svh"

module tcpq_checker
  import tcpq_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [2:0]  rsp_kind,
  input wire logic [31:0] rsp_seq,
  input wire logic [31:0] rsp_id,
  input wire logic        rsp_cls,
  input wire logic [5:0]  rsp_ahead,
  input wire logic        rsp_last
);

  logic [74:0] rsp_payload;
  logic        rsp_single;
  logic        rsp_ack;
  logic        rsp_stall;
  logic        req_take;

  assign rsp_payload = {rsp_kind, rsp_seq, rsp_id, rsp_cls, rsp_ahead, rsp_last};
  assign rsp_single  = (rsp_kind == KIND_ACK) || (rsp_kind == KIND_REMOVED) ||
                       (rsp_kind == KIND_FAIL) || (rsp_kind == KIND_REJECT);
  assign rsp_ack     = (rsp_kind == KIND_ACK);
  assign rsp_stall   = rsp_valid && !rsp_ready;
  assign req_take    = req_valid && req_ready;

  `TCPQ_ASSERT_IMP(a_kind_range, rsp_valid, rsp_kind <= KIND_REJECT, "result kind out of range")
  `TCPQ_ASSERT_IMP(a_single_last, rsp_valid && rsp_single, rsp_last, "single result without last")
  `TCPQ_ASSERT_IMP(a_ahead_ack_only, rsp_valid && !rsp_ack, rsp_ahead == '0, "ahead count off ack")
  `TCPQ_ASSERT_IMP(a_no_req_mid_list, rsp_valid && !rsp_last, !req_take, "request taken in list")
  `TCPQ_ASSERT_NXT(a_hold_stall, rsp_stall, rsp_valid && $stable(rsp_payload), "held result changed")

endmodule

bind two_class_priority_queue tcpq_checker u_tcpq_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_kind  (rsp.kind),
  .rsp_seq   (rsp.seq_number),
  .rsp_id    (rsp.customer_id_res),
  .rsp_cls   (rsp.entry_class_res),
  .rsp_ahead (rsp.ahead_count),
  .rsp_last  (rsp.last)
);

`default_nettype wire

### dv/tcpq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpq_scoreboard
// Watches the request and result channels, keeps its own copy of both rings
// and the arrival number, and compares every result with the oldest one
// predicted. Failures are counted and handed to the testbench top.
// ----------------------------------------------------------------------------

module tcpq_scoreboard
  import tcpq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  tcpq_in_if        req,
  tcpq_out_if       rsp,
  output int        fail_count,
  output int        pending,
  output int        request_count,
  output int        result_count,
  output int        reject_count,
  output int        longest_list
);

  typedef struct packed {
    logic [SEQ_W-1:0]    seq;
    logic [OUT_ID_W-1:0] id;
  } slot_t;

  typedef struct packed {
    logic [2:0]          kind;
    logic [SEQ_W-1:0]    seq;
    logic [OUT_ID_W-1:0] id;
    logic                cls;
    logic [AHEAD_W-1:0]  ahead;
    logic                last;
  } result_t;

  slot_t            prio_ring [QUEUE_DEPTH];
  slot_t            ord_ring  [QUEUE_DEPTH];
  int               prio_rd, prio_len, ord_rd, ord_len;
  logic [SEQ_W-1:0] arrival_seq;
  result_t          expected_results [$];

  task automatic expect_result(input logic [2:0] kind, input logic [SEQ_W-1:0] seq,
                               input logic [OUT_ID_W-1:0] id, input logic cls,
                               input logic [AHEAD_W-1:0] ahead, input logic last);
    result_t r;
    r = '{kind, seq, id, cls, ahead, last};
    expected_results = {expected_results, r};
  endtask

  // Work out every result that one accepted request causes and advance the rings.
  task automatic predict_request(input logic [1:0] op, input logic [31:0] cust,
                                 input logic [1:0] cls);
    logic [OUT_ID_W-1:0] id_kept;
    slot_t               s;
    int                  total;
    int                  n;
    int                  i;
    id_kept = cust & ~({OUT_ID_W{1'b1}} << ID_WIDTH);
    case (op)
      OP_INSERT: begin
        arrival_seq = arrival_seq + 1'b1;
        if (cls == CLS_PRIO) begin
          if (prio_len >= QUEUE_DEPTH) begin
            expect_result(KIND_REJECT, arrival_seq, id_kept, 1'b1, '0, 1'b1);
          end else begin
            expect_result(KIND_ACK, arrival_seq, id_kept, 1'b1, AHEAD_W'(prio_len), 1'b1);
            prio_ring[(prio_rd + prio_len) % QUEUE_DEPTH] = {arrival_seq, id_kept};
            prio_len++;
          end
        end else if (cls == CLS_ORD) begin
          if (ord_len >= QUEUE_DEPTH) begin
            expect_result(KIND_REJECT, arrival_seq, id_kept, 1'b0, '0, 1'b1);
          end else begin
            expect_result(KIND_ACK, arrival_seq, id_kept, 1'b0,
                          AHEAD_W'(prio_len + ord_len), 1'b1);
            ord_ring[(ord_rd + ord_len) % QUEUE_DEPTH] = {arrival_seq, id_kept};
            ord_len++;
          end
        end
        // any other class only burns an arrival number
      end
      OP_REMOVE: begin
        if (prio_len != 0) begin
          s = prio_ring[prio_rd];
          expect_result(KIND_REMOVED, s.seq, s.id, 1'b1, '0, 1'b1);
          prio_rd = (prio_rd + 1) % QUEUE_DEPTH;
          prio_len--;
        end else if (ord_len != 0) begin
          s = ord_ring[ord_rd];
          expect_result(KIND_REMOVED, s.seq, s.id, 1'b0, '0, 1'b1);
          ord_rd = (ord_rd + 1) % QUEUE_DEPTH;
          ord_len--;
        end else begin
          expect_result(KIND_FAIL, '0, '0, 1'b0, '0, 1'b1);
        end
      end
      OP_LIST: begin
        total = prio_len + ord_len;
        n     = 0;
        expect_result(KIND_LIST_HDR, '0, '0, 1'b0, '0, total == 0);
        for (i = 0; i < prio_len; i++) begin
          s = prio_ring[(prio_rd + i) % QUEUE_DEPTH];
          n++;
          expect_result(KIND_LIST_ENT, s.seq, s.id, 1'b1, '0, n == total);
        end
        for (i = 0; i < ord_len; i++) begin
          s = ord_ring[(ord_rd + i) % QUEUE_DEPTH];
          n++;
          expect_result(KIND_LIST_ENT, s.seq, s.id, 1'b0, '0, n == total);
        end
        if (total + 1 > longest_list) begin
          longest_list = total + 1;
        end
      end
      default: ;
    endcase
  endtask

  function automatic bit field_ok(input string name, input logic [31:0] want,
                                  input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic check_result();
    result_t want;
    bit      ok;
    if (expected_results.size() == 0) begin
      $display("%0t: result with nothing expected: kind %0d seq 0x%0h id 0x%0h",
               $time, rsp.kind, rsp.seq_number, rsp.customer_id_res);
      fail_count++;
      return;
    end
    want = expected_results[0];
    expected_results.delete(0);
    if (want.kind == KIND_REJECT) begin
      reject_count++;
    end
    ok = 1'b1;
    ok &= field_ok("kind", 32'(want.kind), 32'(rsp.kind));
    ok &= field_ok("seq_number", want.seq, rsp.seq_number);
    ok &= field_ok("customer_id_res", want.id, rsp.customer_id_res);
    ok &= field_ok("entry_class_res", 32'(want.cls), 32'(rsp.entry_class_res));
    ok &= field_ok("ahead_count", 32'(want.ahead), 32'(rsp.ahead_count));
    ok &= field_ok("last", 32'(want.last), 32'(rsp.last));
    if (!ok) begin
      fail_count++;
    end
  endtask

  // Predict before checking: results of an earlier request already sit ahead.
  always @(posedge clk) begin
    if (rst) begin
      prio_rd     = 0;
      prio_len    = 0;
      ord_rd      = 0;
      ord_len     = 0;
      arrival_seq = '0;
      expected_results.delete();
    end else begin
      if (req.valid && req.ready) begin
        request_count++;
        predict_request(req.op, req.customer_id, req.entry_class);
      end
      if (rsp.valid && rsp.ready) begin
        result_count++;
        check_result();
      end
    end
    pending = expected_results.size();
  end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the two-class priority queue. A directed opening
// covers empty rings, extreme ids, unknown classes and the unused op; then
// structured random phases fill, saturate and drain both rings under random
// stalls on both channels, with a long hold-off on the result side.
// ----------------------------------------------------------------------------

module tb;
  import tcpq_pkg::*;

  // Codes the package leaves unnamed: the spare op and the two unknown classes.
  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam logic [1:0] CLS_UNKNOWN = 2'd2;
  localparam logic [1:0] CLS_UNUSED  = 2'd3;

  localparam int ITEM_TARGET  = 380;
  localparam int STALL_LIMIT  = 2000;  // idle cycles before the watchdog fires
  localparam int DRAIN_CYCLES = 20;    // quiet time after the last result
  localparam int HOLD_CYCLES  = 150;   // long hold-off on the result side

  typedef enum {PH_FILL, PH_DRAIN, PH_MIXED} phase_t;

  logic clk;
  logic rst;

  tcpq_in_if  req_ch ();
  tcpq_out_if rsp_ch ();

  int fail_count;
  int pending;
  int request_count;
  int result_count;
  int reject_count;
  int longest_list;

  int sent;          // requests accepted so far, as seen by the sender
  bit quiet_mode;    // when set, neither side inserts gaps
  int hold_request;  // cycles of hold-off asked of the result side
  int stall_cycles;

  two_class_priority_queue u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  tcpq_scoreboard u_checker (
    .clk           (clk),
    .rst           (rst),
    .req           (req_ch),
    .rsp           (rsp_ch),
    .fail_count    (fail_count),
    .pending       (pending),
    .request_count (request_count),
    .result_count  (result_count),
    .reject_count  (reject_count),
    .longest_list  (longest_list)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (quiet_mode) begin
      return 0;
    end
    r = $urandom_range(99);
    if (r < 55) begin
      return 0;
    end
    if (r < 85) begin
      return $urandom_range(3, 1);
    end
    if (r < 97) begin
      return $urandom_range(10, 4);
    end
    return $urandom_range(40, 20);
  endfunction

  // Favor the all-zero and all-one ids now and then so every bit sees both values.
  function automatic logic [31:0] random_id();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Lean toward one class so a phase can push that ring to full.
  function automatic logic [1:0] random_class(input bit lean_prio);
    int r;
    r = $urandom_range(99);
    if (r < 4) begin
      return $urandom_range(1) ? CLS_UNKNOWN : CLS_UNUSED;
    end
    if (r < 80) begin
      return lean_prio ? CLS_PRIO : CLS_ORD;
    end
    return lean_prio ? CLS_ORD : CLS_PRIO;
  endfunction

  // Offer one request after a random gap and hold it until the block takes it.
  // Valid stays high from one request into the next when there is no gap.
  task automatic send_request(input logic [1:0] op, input logic [31:0] cust,
                              input logic [1:0] cls);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      req_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_ch.valid       = 1'b1;
    req_ch.op          = op;
    req_ch.customer_id = cust;
    req_ch.entry_class = cls;
    do @(posedge clk); while (!req_ch.ready);
    sent++;
  endtask

  // Pick an op with weights that depend on the phase: fill phases mostly
  // insert, drain phases mostly remove, and a list shows up in all of them.
  task automatic send_random(input phase_t ph, input bit lean_prio);
    int r;
    int ins_pct;
    int rem_pct;
    r = $urandom_range(99);
    case (ph)
      PH_FILL: begin
        ins_pct = 75;
        rem_pct = 12;
      end
      PH_DRAIN: begin
        ins_pct = 20;
        rem_pct = 68;
      end
      default: begin
        ins_pct = 45;
        rem_pct = 40;
      end
    endcase
    if (r < ins_pct) begin
      send_request(OP_INSERT, random_id(), random_class(lean_prio));
    end else if (r < ins_pct + rem_pct) begin
      send_request(OP_REMOVE, random_id(), random_class(lean_prio));
    end else if (r < 98) begin
      send_request(OP_LIST, random_id(), random_class(lean_prio));
    end else begin
      send_request(OP_UNUSED, random_id(), random_class(lean_prio));
    end
  endtask

  // Drop valid and hold off until every predicted result has arrived.
  task automatic idle_until_drained();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Result side: random ready, or a long hold-off when the sender asks for one.
  // The hold-off is counted here, in cycles, independent of the sender.
  initial begin
    int gap;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        rsp_ch.ready = 1'b0;
        repeat (hold_request - 1) @(negedge clk);
        hold_request = 0;
      end else begin
        gap = pick_gap();
        if (gap == 0) begin
          rsp_ch.ready = 1'b1;
        end else begin
          rsp_ch.ready = 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog: nothing moved on either channel for %0d cycles",
               $time, STALL_LIMIT);
      $display("two_class_priority_queue: mismatch");
      $finish;
    end
  end

  initial begin
    phase_t ph;
    int     len;
    int     i;
    bit     lean_prio;

    // Drive every input to a known value from time zero.
    rst                = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.op          = OP_INSERT;
    req_ch.customer_id = '0;
    req_ch.entry_class = CLS_ORD;
    quiet_mode         = 1'b0;
    hold_request       = 0;
    sent               = 0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed opening. Start on empty rings: a remove must fail and a list
    // must give the header alone.
    send_request(OP_REMOVE, '0, CLS_ORD);
    send_request(OP_LIST, '1, CLS_PRIO);
    // Extreme ids in both classes; the ordinary one counts the priority entry.
    send_request(OP_INSERT, '0, CLS_PRIO);
    send_request(OP_INSERT, '1, CLS_ORD);
    // Unknown classes burn an arrival number and give nothing back.
    send_request(OP_INSERT, 32'h8000_0001, CLS_UNKNOWN);
    send_request(OP_INSERT, 32'h7FFF_FFFE, CLS_UNUSED);
    send_request(OP_INSERT, 32'h1234_5678, CLS_ORD);
    // A late priority entry still goes ahead of both ordinary ones.
    send_request(OP_INSERT, 32'hA5A5_5A5A, CLS_PRIO);
    // The spare op must be ignored entirely.
    send_request(OP_UNUSED, '1, CLS_UNUSED);
    send_request(OP_LIST, '0, CLS_ORD);
    // Drain in strict priority order, then one remove too many.
    repeat (5) send_request(OP_REMOVE, random_id(), CLS_ORD);
    send_request(OP_LIST, '0, CLS_ORD);
    idle_until_drained();

    // Saturate both rings past full, list the longest possible result run,
    // then drain past empty.
    repeat (QUEUE_DEPTH + 2) send_request(OP_INSERT, random_id(), CLS_PRIO);
    repeat (QUEUE_DEPTH + 2) send_request(OP_INSERT, random_id(), CLS_ORD);
    send_request(OP_LIST, random_id(), CLS_ORD);
    repeat (2 * QUEUE_DEPTH + 4) send_request(OP_REMOVE, random_id(), random_class(1'b0));
    idle_until_drained();

    // Long hold-off on the result side while the sender keeps offering
    // back-to-back requests, so the block backs up and stalls its input.
    hold_request = HOLD_CYCLES;
    quiet_mode   = 1'b1;
    for (i = 0; i < 20; i++) begin
      send_random(PH_FILL, 1'($urandom_range(1)));
    end
    quiet_mode = 1'b0;
    idle_until_drained();

    // Random phases until the item budget is spent; some run without gaps,
    // and some end with a full pause until the results have caught up.
    while (sent < ITEM_TARGET) begin
      case ($urandom_range(2))
        0:       ph = PH_FILL;
        1:       ph = PH_DRAIN;
        default: ph = PH_MIXED;
      endcase
      lean_prio  = 1'($urandom_range(1));
      len        = $urandom_range(45, 20);
      quiet_mode = ($urandom_range(3) == 0);
      for (i = 0; i < len; i++) begin
        send_random(ph, lean_prio);
      end
      quiet_mode = 1'b0;
      if ($urandom_range(3) == 0) begin
        idle_until_drained();
      end
    end

    // Wait for the last results, then a little longer to catch strays.
    idle_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d requests and %0d results, %0d inserts refused at a full ring,",
             request_count, result_count, reject_count);
    $display("and a longest list of %0d results.", longest_list);
    if (fail_count == 0 && pending == 0) begin
      $display("two_class_priority_queue: match");
    end else begin
      $display("two_class_priority_queue: mismatch");
    end
    $finish;
  end

endmodule

### two_class_priority_queue.f
+incdir+hdl
hdl/tcpq_pkg.sv
hdl/tcpq_in_if.sv
hdl/tcpq_out_if.sv
hdl/tcpq_ring.sv
hdl/tcpq_ctrl.sv
hdl/two_class_priority_queue.sv
hdl/tcpq_checker.sv
dv/tcpq_checker.sv
dv/tb.sv
